// ===== rtl/core/gbs_pkg.sv =====
`default_nettype none
package gbs_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int LOG_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_LOG_GROUP   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] grid_width;
        logic [CFG_DATA_W-1:0] grid_height;
        logic [LOG_W-1:0]      log_group;
    } t_cfg;

    // per-stage control that rides along with each item
    typedef struct packed {
        logic valid;
        logic oor;
    } t_tag;

endpackage
`default_nettype wire

// ===== rtl/core/gbs_in_if.sv =====
`default_nettype none
interface gbs_in_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] block_col;
    logic [COORD_BITS-1:0] block_row;

    modport source (output valid, block_col, block_row, input ready);
    modport sink   (input valid, block_col, block_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gbs_out_if.sv =====
`default_nettype none
interface gbs_out_if #(
    parameter int COORD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] new_col;
    logic [COORD_BITS-1:0] new_row;
    logic                  out_of_range;

    modport source (output valid, new_col, new_row, out_of_range, input ready);
    modport sink   (input valid, new_col, new_row, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gbs_prep.sv =====
`default_nettype none
// Front stage: linear id, offset inside the group span, clipped group height.
module gbs_prep #(
    parameter int N = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire gbs_pkg::t_cfg i_cfg,
    input  wire                i_v,
    input  wire [N-1:0]        i_col,
    input  wire [N-1:0]        i_row,
    input  wire                i_rdy_dn,
    output logic               o_rdy,
    output gbs_pkg::t_tag      o_tag,
    output logic [2*N-1:0]     o_dm,
    output logic [2*N-1:0]     o_dp,
    output logic [N-1:0]       o_c,
    output logic [N-1:0]       o_first
);
    import gbs_pkg::*;

    logic [N+CFG_DATA_W-1:0] w_ext;
    logic [N+CFG_DATA_W-1:0] h_ext;
    logic [N-1:0]            w;
    logic [N-1:0]            h;
    logic [N-1:0]            g;
    logic [N-1:0]            mask;
    logic [N-1:0]            r;
    logic [N-1:0]            diff;
    logic [2*N-1:0]          prod_p;
    logic [2*N-1:0]          prod_m;

    t_tag           r_tag, n_tag;
    logic [2*N-1:0] r_dm, n_dm;
    logic [2*N-1:0] r_dp, n_dp;
    logic [N-1:0]   r_c, n_c;
    logic [N-1:0]   r_first, n_first;

    assign w_ext = {{N{1'b0}}, i_cfg.grid_width};
    assign h_ext = {{N{1'b0}}, i_cfg.grid_height};
    assign w     = w_ext[N-1:0];
    assign h     = h_ext[N-1:0];

    // g is zero when the group is taller than the coordinate range: no clip then
    assign g    = {{(N-1){1'b0}}, 1'b1} << i_cfg.log_group;
    assign mask = g - {{(N-1){1'b0}}, 1'b1};
    assign r    = i_row & mask;

    assign prod_p = {{N{1'b0}}, i_row} * {{N{1'b0}}, w};
    assign prod_m = {{N{1'b0}}, r} * {{N{1'b0}}, w};

    always_comb begin
        n_first   = i_row & ~mask;
        diff      = h - n_first;
        n_tag.valid = i_v;
        n_tag.oor   = (i_col >= w) || (i_row >= h);
        n_dp      = prod_p + {{N{1'b0}}, i_col};
        n_dm      = prod_m + {{N{1'b0}}, i_col};
        if ((g == '0) || (diff < g)) begin
            n_c = diff;
        end else begin
            n_c = g;
        end
    end

    assign o_rdy = !r_tag.valid || i_rdy_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (o_rdy) begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_dm    <= n_dm;
            r_dp    <= n_dp;
            r_c     <= n_c;
            r_first <= n_first;
        end
    end

    assign o_tag   = r_tag;
    assign o_dm    = r_dm;
    assign o_dp    = r_dp;
    assign o_c     = r_c;
    assign o_first = r_first;

endmodule
`default_nettype wire

// ===== rtl/core/gbs_div_cell.sv =====
`default_nettype none
// One restoring-division step on two dividends that share the divisor.
// dm shifts its quotient bits in from the right; dp keeps only the remainder.
module gbs_div_cell #(
    parameter int N = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire gbs_pkg::t_tag i_tag,
    input  wire [2*N-1:0]      i_dm,
    input  wire [2*N-1:0]      i_dp,
    input  wire [N-1:0]        i_rem_m,
    input  wire [N-1:0]        i_rem_p,
    input  wire [N-1:0]        i_c,
    input  wire [N-1:0]        i_first,
    input  wire                i_rdy_dn,
    output logic               o_rdy,
    output gbs_pkg::t_tag      o_tag,
    output logic [2*N-1:0]     o_dm,
    output logic [2*N-1:0]     o_dp,
    output logic [N-1:0]       o_rem_m,
    output logic [N-1:0]       o_rem_p,
    output logic [N-1:0]       o_c,
    output logic [N-1:0]       o_first
);
    import gbs_pkg::*;

    logic [N:0] pa;
    logic [N:0] pb;
    logic [N:0] da;
    logic [N:0] db;
    logic       ge_a;
    logic       ge_b;

    t_tag           r_tag;
    logic [2*N-1:0] r_dm, n_dm;
    logic [2*N-1:0] r_dp, n_dp;
    logic [N-1:0]   r_rem_m, n_rem_m;
    logic [N-1:0]   r_rem_p, n_rem_p;
    logic [N-1:0]   r_c;
    logic [N-1:0]   r_first;

    always_comb begin
        pa      = {i_rem_m, i_dm[2*N-1]};
        pb      = {i_rem_p, i_dp[2*N-1]};
        da      = pa - {1'b0, i_c};
        db      = pb - {1'b0, i_c};
        ge_a    = pa >= {1'b0, i_c};
        ge_b    = pb >= {1'b0, i_c};
        n_rem_m = ge_a ? da[N-1:0] : pa[N-1:0];
        n_rem_p = ge_b ? db[N-1:0] : pb[N-1:0];
        n_dm    = {i_dm[2*N-2:0], ge_a};
        n_dp    = {i_dp[2*N-2:0], 1'b0};
    end

    assign o_rdy = !r_tag.valid || i_rdy_dn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (o_rdy) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_dm    <= n_dm;
            r_dp    <= n_dp;
            r_rem_m <= n_rem_m;
            r_rem_p <= n_rem_p;
            r_c     <= i_c;
            r_first <= i_first;
        end
    end

    assign o_tag   = r_tag;
    assign o_dm    = r_dm;
    assign o_dp    = r_dp;
    assign o_rem_m = r_rem_m;
    assign o_rem_p = r_rem_p;
    assign o_c     = r_c;
    assign o_first = r_first;

endmodule
`default_nettype wire

// ===== rtl/core/grouped_block_id_swizzle_top.sv =====
`default_nettype none
// Grouped block-id swizzle.
// Input channel i_blk carries one block coordinate (block_col, block_row) per item;
// output channel o_swz returns the swizzled coordinate, or zeros with out_of_range
// set when the coordinate lies outside the configured grid. One result per item,
// in order. Grid width, grid height and log2 group height are written through the
// cfg port (index 0, 1, 2; other indexes ignored); the user must write them only
// while no item is in flight, as the block itself does not enforce it. The stages
// are one front stage with the two multipliers, a row of 2*COORD_BITS division cells
// that each retire one quotient bit, and the output register. One item per cycle is
// taken and returned steadily while the output is not stalled. Every stage moves on
// when its successor frees up, so empty stages close up behind a stalled output and
// input is still taken until the whole row is full. Reset sets the grid to 1 x 1
// with group height 1 and empties the pipeline.
module grouped_block_id_swizzle_top #(
    parameter int COORD_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [gbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [gbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    gbs_in_if.sink                         i_blk,
    gbs_out_if.source                      o_swz
);
    import gbs_pkg::*;

    localparam int N      = COORD_BITS;
    localparam int NCELLS = 2 * COORD_BITS;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= CFG_DATA_W'(1);
            r_cfg.grid_height <= CFG_DATA_W'(1);
            r_cfg.log_group   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_WIDTH:  r_cfg.grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_cfg.grid_height <= i_cfg_data;
                CFG_LOG_GROUP:   r_cfg.log_group   <= i_cfg_data[LOG_W-1:0];
                default: ;
            endcase
        end
    end

    t_tag           tag   [0:NCELLS];
    logic [2*N-1:0] dm    [0:NCELLS];
    logic [2*N-1:0] dp    [0:NCELLS];
    logic [N-1:0]   rem_m [0:NCELLS];
    logic [N-1:0]   rem_p [0:NCELLS];
    logic [N-1:0]   c     [0:NCELLS];
    logic [N-1:0]   first [0:NCELLS];
    logic           rdy   [0:NCELLS];
    logic           out_rdy;

    gbs_prep #(.N(N)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_v      (i_blk.valid),
        .i_col    (i_blk.block_col),
        .i_row    (i_blk.block_row),
        .i_rdy_dn (rdy[0]),
        .o_rdy    (i_blk.ready),
        .o_tag    (tag[0]),
        .o_dm     (dm[0]),
        .o_dp     (dp[0]),
        .o_c      (c[0]),
        .o_first  (first[0])
    );

    assign rem_m[0]    = '0;
    assign rem_p[0]    = '0;
    assign rdy[NCELLS] = out_rdy;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        gbs_div_cell #(.N(N)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tag    (tag[k]),
            .i_dm     (dm[k]),
            .i_dp     (dp[k]),
            .i_rem_m  (rem_m[k]),
            .i_rem_p  (rem_p[k]),
            .i_c      (c[k]),
            .i_first  (first[k]),
            .i_rdy_dn (rdy[k+1]),
            .o_rdy    (rdy[k]),
            .o_tag    (tag[k+1]),
            .o_dm     (dm[k+1]),
            .o_dp     (dp[k+1]),
            .o_rem_m  (rem_m[k+1]),
            .o_rem_p  (rem_p[k+1]),
            .o_c      (c[k+1]),
            .o_first  (first[k+1])
        );
    end

    // output register
    logic         r_out_v;
    logic [N-1:0] r_col, n_col;
    logic [N-1:0] r_row, n_row;
    logic         r_oor;

    always_comb begin
        if (tag[NCELLS].oor) begin
            n_col = '0;
            n_row = '0;
        end else begin
            // quotient fits the coordinate width, so its low bits are the column
            n_col = dm[NCELLS][N-1:0];
            n_row = first[NCELLS] + rem_p[NCELLS];
        end
    end

    assign out_rdy = !r_out_v || o_swz.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_rdy) begin
            r_out_v <= tag[NCELLS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_col <= n_col;
            r_row <= n_row;
            r_oor <= tag[NCELLS].oor;
        end
    end

    assign o_swz.valid        = r_out_v;
    assign o_swz.new_col      = r_col;
    assign o_swz.new_row      = r_row;
    assign o_swz.out_of_range = r_oor;

endmodule
`default_nettype wire
